>>> rtl/core/mmeh_pkg.sv
package mmeh_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int SET_IDX_W   = 4;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 9;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  localparam sample_t EMPTY_MIN = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t EMPTY_MAX = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  localparam logic [3:0] FUNC_ACC_BAND  = 4'd0;
  localparam logic [3:0] FUNC_ACC_WIDE  = 4'd1;
  localparam logic [3:0] FUNC_APPEND    = 4'd2;
  localparam logic [3:0] FUNC_WRITE_COL = 4'd3;
  localparam logic [3:0] FUNC_CLR_BAND  = 4'd4;
  localparam logic [3:0] FUNC_CLR_WIDE  = 4'd5;
  localparam logic [3:0] FUNC_CLR_ALL   = 4'd6;
  localparam logic [3:0] FUNC_RST_ACC   = 4'd7;
  localparam logic [3:0] FUNC_READ      = 4'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BANDS = 4'd1;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACC,
    OP_APPEND,
    OP_WCOL,
    OP_CLR_SET,
    OP_CLR_ALL,
    OP_RST_ACC,
    OP_READ
  } op_e;

  typedef struct packed {
    logic [3:0] func;
    logic [2:0] band;
    logic       wide;
    logic [1:0] mode;
    logic [7:0] column;
    sample_t    sample;
  } item_t;

  typedef struct packed {
    sample_t min_value;
    sample_t max_value;
    logic    recorded;
  } result_t;

  typedef struct packed {
    op_e                  op;
    logic                 hit;
    logic [SET_IDX_W-1:0] set;
    logic [1:0]           mode;
    logic [7:0]           column;
    sample_t              sample;
  } cmd_t;

  typedef struct packed {
    sample_t mn;
    sample_t mx;
  } pair_t;

  localparam pair_t EMPTY_PAIR = '{mn: EMPTY_MIN, mx: EMPTY_MAX};

endpackage

>>> rtl/core/mmeh_ram.sv
module mmeh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

>>> rtl/core/mmeh_fifo.sv
module mmeh_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]      cnt_q, cnt_d;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

>>> rtl/core/mmeh_front.sv
module mmeh_front #(
  parameter int NUM_BANDS = 4,
  parameter int NUM_MODES = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            accept_i,
  input  mmeh_pkg::item_t item_i,
  output logic            full_o,
  output logic            cmd_valid_o,
  output mmeh_pkg::cmd_t  cmd_o,
  input  logic            cmd_pop_i
);

  mmeh_pkg::cmd_t cmd;
  logic           band_ok;
  logic           mode_ok;
  logic           cmd_empty;

  assign band_ok = (4'(item_i.band) < 4'(NUM_BANDS));
  assign mode_ok = (4'(item_i.mode) < 4'(NUM_MODES));

  always_comb begin
    cmd        = '0;
    cmd.op     = mmeh_pkg::OP_NOP;
    cmd.mode   = item_i.mode;
    cmd.column = item_i.column;
    cmd.sample = item_i.sample;
    unique case (item_i.func)
      mmeh_pkg::FUNC_ACC_BAND: begin
        cmd.op  = mmeh_pkg::OP_ACC;
        cmd.set = mmeh_pkg::SET_IDX_W'(item_i.band);
        cmd.hit = band_ok && mode_ok;
      end
      mmeh_pkg::FUNC_ACC_WIDE: begin
        cmd.op  = mmeh_pkg::OP_ACC;
        cmd.set = mmeh_pkg::SET_IDX_W'(NUM_BANDS);
        cmd.hit = mode_ok;
      end
      mmeh_pkg::FUNC_APPEND: begin
        cmd.op  = mmeh_pkg::OP_APPEND;
        cmd.hit = 1'b1;
      end
      mmeh_pkg::FUNC_WRITE_COL: begin
        cmd.op  = mmeh_pkg::OP_WCOL;
        cmd.hit = 1'b1;
      end
      mmeh_pkg::FUNC_CLR_BAND: begin
        cmd.op  = mmeh_pkg::OP_CLR_SET;
        cmd.set = mmeh_pkg::SET_IDX_W'(item_i.band);
        cmd.hit = band_ok;
      end
      mmeh_pkg::FUNC_CLR_WIDE: begin
        cmd.op  = mmeh_pkg::OP_CLR_SET;
        cmd.set = mmeh_pkg::SET_IDX_W'(NUM_BANDS);
        cmd.hit = 1'b1;
      end
      mmeh_pkg::FUNC_CLR_ALL: begin
        cmd.op  = mmeh_pkg::OP_CLR_ALL;
        cmd.hit = 1'b1;
      end
      mmeh_pkg::FUNC_RST_ACC: begin
        cmd.op  = mmeh_pkg::OP_RST_ACC;
        cmd.hit = 1'b1;
      end
      mmeh_pkg::FUNC_READ: begin
        cmd.op  = mmeh_pkg::OP_READ;
        cmd.set = item_i.wide ? mmeh_pkg::SET_IDX_W'(NUM_BANDS)
                              : mmeh_pkg::SET_IDX_W'(item_i.band);
        cmd.hit = (item_i.wide || band_ok) && mode_ok;
      end
      default: begin
        cmd.op = mmeh_pkg::OP_NOP;
      end
    endcase
  end

  mmeh_fifo #(
    .WIDTH ($bits(mmeh_pkg::cmd_t)),
    .DEPTH (2)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept_i),
    .data_i  (cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

>>> rtl/core/mmeh_back.sv
module mmeh_back #(
  parameter int NUM_BANDS   = 4,
  parameter int NUM_MODES   = 4,
  parameter int MAX_COLUMNS = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_write_i,
  input  logic [mmeh_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mmeh_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                cmd_valid_i,
  input  mmeh_pkg::cmd_t                      cmd_i,
  output logic                                cmd_pop_o,
  input  logic                                res_full_i,
  output logic                                res_push_o,
  output mmeh_pkg::result_t                   res_o,
  output logic                                init_busy_o
);

  localparam int SETS = NUM_BANDS + 1;
  localparam int SW   = $clog2(SETS);
  localparam int CW   = $clog2(MAX_COLUMNS);
  localparam int NW   = $clog2(MAX_COLUMNS + 1);
  localparam int AW   = SW + CW;
  localparam int MW   = (NUM_MODES > 1) ? $clog2(NUM_MODES) : 1;
  localparam int BW   = (CW > 1) ? $clog2(CW) : 1;
  localparam int SUMW = ((CW > 8) ? CW : 8) + 1;
  localparam int DEPTH = SETS << CW;

  typedef mmeh_pkg::pair_t [NUM_MODES-1:0] row_t;

  localparam logic [2:0] ST_INIT   = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_NORM   = 3'd2;
  localparam logic [2:0] ST_APPEND = 3'd3;
  localparam logic [2:0] ST_WCOL   = 3'd4;
  localparam logic [2:0] ST_CLEAR  = 3'd5;
  localparam logic [2:0] ST_RDATA  = 3'd6;

  localparam logic [AW-1:0] LAST_ROW = {SW'(SETS - 1), {CW{1'b1}}};
  localparam logic [SW-1:0] WIDE_SET = SW'(NUM_BANDS);

  logic [2:0]    state_q, state_d;
  mmeh_pkg::cmd_t cur_q, cur_d;
  logic [SW-1:0] set_q, set_d;
  logic [AW-1:0] sweep_q, sweep_d, end_q, end_d;
  logic [BW-1:0] bit_q, bit_d;
  logic [NW-1:0] rem_q, rem_d;
  logic          rec_q, rec_d;
  logic          norm_q, norm_d;
  logic [8:0]    cc_q, cc_d;
  logic [2:0]    ab_q, ab_d;
  logic [CW-1:0] head_raw_q [SETS];
  logic [CW-1:0] head_raw_d [SETS];
  logic [CW-1:0] head_mod_q [SETS];
  logic [CW-1:0] head_mod_d [SETS];
  row_t          acc_q [SETS];
  row_t          acc_d [SETS];

  row_t          empty_row;
  row_t          acc_row;
  row_t          rd_row;
  logic [NW-1:0] n_cols;
  logic [SW-1:0] cmd_set;
  logic [SW-1:0] slot_set;
  logic [7:0]    slot_col;
  logic [SUMW-1:0] slot_sum;
  logic [CW-1:0] slot;
  logic          col_ok;
  logic          set_active;
  logic [CW:0]   head_inc;
  logic [CW-1:0] head_next;
  logic [NW:0]   rem_t;
  logic [NW-1:0] rem_n;
  logic          rem_bit;
  mmeh_pkg::pair_t fold_pair;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [$bits(row_t)-1:0] ram_rdata;

  assign empty_row = {NUM_MODES{mmeh_pkg::EMPTY_PAIR}};
  assign rd_row    = row_t'(ram_rdata);
  assign init_busy_o = (state_q == ST_INIT);

  always_comb begin
    if (cc_q == 9'd0) begin
      n_cols = NW'(1);
    end else if (int'(cc_q) > MAX_COLUMNS) begin
      n_cols = NW'(MAX_COLUMNS);
    end else begin
      n_cols = NW'(cc_q);
    end
  end

  assign cmd_set  = SW'(cmd_i.set);
  assign slot_set = (state_q == ST_IDLE) ? cmd_set : set_q;
  assign slot_col = (state_q == ST_IDLE) ? cmd_i.column : cur_q.column;
  assign slot_sum = SUMW'(head_mod_q[slot_set]) + SUMW'(slot_col);
  assign slot     = (slot_sum >= SUMW'(n_cols)) ? CW'(slot_sum - SUMW'(n_cols)) : CW'(slot_sum);
  assign col_ok   = (SUMW'(slot_col) < SUMW'(n_cols));
  assign acc_row  = acc_q[slot_set];

  assign set_active = (4'(set_q) < 4'(ab_q)) || (set_q == WIDE_SET);
  assign head_inc   = (CW+1)'(head_mod_q[set_q]) + 1'b1;
  assign head_next  = ((NW+1)'(head_inc) == (NW+1)'(n_cols)) ? '0 : CW'(head_inc);

  // One restoring step of head modulo column count.
  assign rem_bit = head_raw_q[set_q][CW - 1 - int'(bit_q)];
  assign rem_t   = {rem_q, rem_bit};
  assign rem_n   = (rem_t >= {1'b0, n_cols}) ? NW'(rem_t - {1'b0, n_cols}) : NW'(rem_t);

  always_comb begin
    fold_pair = acc_row[MW'(cmd_i.mode)];
    if ($signed(cmd_i.sample) < $signed(fold_pair.mn)) begin
      fold_pair.mn = cmd_i.sample;
    end
    if ($signed(cmd_i.sample) > $signed(fold_pair.mx)) begin
      fold_pair.mx = cmd_i.sample;
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    set_d      = set_q;
    sweep_d    = sweep_q;
    end_d      = end_q;
    bit_d      = bit_q;
    rem_d      = rem_q;
    rec_d      = rec_q;
    norm_d     = norm_q;
    cc_d       = cc_q;
    ab_d       = ab_q;
    head_raw_d = head_raw_q;
    head_mod_d = head_mod_q;
    acc_d      = acc_q;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    res_o      = '0;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;

    unique case (state_q)
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        if (sweep_q == end_q) begin
          state_d = ST_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_IDLE: begin
        if (norm_q) begin
          state_d = ST_NORM;
          set_d   = '0;
          bit_d   = '0;
          rem_d   = '0;
        end else if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o  = 1'b1;
          cur_d      = cmd_i;
          res_push_o = 1'b1;
          unique case (cmd_i.op)
            mmeh_pkg::OP_ACC: begin
              if (cmd_i.hit) begin
                acc_d[cmd_set][MW'(cmd_i.mode)] = fold_pair;
              end
            end
            mmeh_pkg::OP_APPEND: begin
              res_push_o = 1'b0;
              set_d      = '0;
              state_d    = ST_APPEND;
            end
            mmeh_pkg::OP_WCOL: begin
              if (col_ok) begin
                res_push_o = 1'b0;
                set_d      = '0;
                state_d    = ST_WCOL;
              end
            end
            mmeh_pkg::OP_CLR_SET: begin
              if (cmd_i.hit) begin
                acc_d[cmd_set]      = empty_row;
                head_raw_d[cmd_set] = '0;
                head_mod_d[cmd_set] = '0;
                sweep_d    = {cmd_set, {CW{1'b0}}};
                end_d      = {cmd_set, {CW{1'b1}}};
                res_push_o = 1'b0;
                state_d    = ST_CLEAR;
              end
            end
            mmeh_pkg::OP_CLR_ALL: begin
              for (int s = 0; s < SETS; s++) begin
                head_raw_d[s] = '0;
                head_mod_d[s] = '0;
              end
              rec_d      = 1'b0;
              sweep_d    = '0;
              end_d      = LAST_ROW;
              res_push_o = 1'b0;
              state_d    = ST_CLEAR;
            end
            mmeh_pkg::OP_RST_ACC: begin
              for (int s = 0; s < SETS; s++) begin
                acc_d[s] = empty_row;
              end
            end
            mmeh_pkg::OP_READ: begin
              if (cmd_i.hit && col_ok) begin
                ram_re     = 1'b1;
                ram_raddr  = {cmd_set, slot};
                res_push_o = 1'b0;
                state_d    = ST_RDATA;
              end else begin
                res_o.min_value = mmeh_pkg::EMPTY_MIN;
                res_o.max_value = mmeh_pkg::EMPTY_MAX;
              end
            end
            mmeh_pkg::OP_NOP: begin
              cur_d = cmd_i;
            end
          endcase
        end
      end
      ST_NORM: begin
        rem_d = rem_n;
        bit_d = bit_q + 1'b1;
        if (int'(bit_q) == CW - 1) begin
          head_mod_d[set_q] = CW'(rem_n);
          rem_d = '0;
          bit_d = '0;
          if (set_q == WIDE_SET) begin
            norm_d  = 1'b0;
            state_d = ST_IDLE;
          end else begin
            set_d = set_q + 1'b1;
          end
        end
      end
      ST_APPEND: begin
        if (set_active) begin
          ram_we            = 1'b1;
          ram_waddr         = {set_q, head_mod_q[set_q]};
          head_raw_d[set_q] = head_next;
          head_mod_d[set_q] = head_next;
        end
        if (set_q == WIDE_SET) begin
          rec_d      = 1'b1;
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          set_d = set_q + 1'b1;
        end
      end
      ST_WCOL: begin
        if (set_active) begin
          ram_we    = 1'b1;
          ram_waddr = {set_q, slot};
        end
        if (set_q == WIDE_SET) begin
          rec_d      = 1'b1;
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          set_d = set_q + 1'b1;
        end
      end
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_q;
        if (sweep_q == end_q) begin
          res_push_o = 1'b1;
          state_d    = ST_IDLE;
        end else begin
          sweep_d = sweep_q + 1'b1;
        end
      end
      ST_RDATA: begin
        res_push_o      = 1'b1;
        res_o.min_value = rd_row[MW'(cur_q.mode)].mn;
        res_o.max_value = rd_row[MW'(cur_q.mode)].mx;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cfg_write_i) begin
      if (cfg_index_i == mmeh_pkg::CFG_COLUMN_COUNT) begin
        cc_d   = cfg_data_i;
        norm_d = 1'b1;
        // A new column count restarts a reduction pass that is under way.
        if (state_q == ST_NORM) begin
          state_d = ST_IDLE;
        end
      end else if (cfg_index_i == mmeh_pkg::CFG_ACTIVE_BANDS) begin
        ab_d = cfg_data_i[2:0];
      end
    end

    res_o.recorded = rec_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      set_q   <= '0;
      sweep_q <= '0;
      end_q   <= LAST_ROW;
      bit_q   <= '0;
      rem_q   <= '0;
      rec_q   <= 1'b0;
      norm_q  <= 1'b0;
      cc_q    <= 9'd256;
      ab_q    <= 3'd4;
      for (int s = 0; s < SETS; s++) begin
        head_raw_q[s] <= '0;
        head_mod_q[s] <= '0;
        acc_q[s]      <= {NUM_MODES{mmeh_pkg::EMPTY_PAIR}};
      end
    end else begin
      state_q    <= state_d;
      set_q      <= set_d;
      sweep_q    <= sweep_d;
      end_q      <= end_d;
      bit_q      <= bit_d;
      rem_q      <= rem_d;
      rec_q      <= rec_d;
      norm_q     <= norm_d;
      cc_q       <= cc_d;
      ab_q       <= ab_d;
      head_raw_q <= head_raw_d;
      head_mod_q <= head_mod_d;
      acc_q      <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
  end

  mmeh_ram #(
    .WIDTH ($bits(row_t)),
    .DEPTH (DEPTH)
  ) u_history (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ((state_q == ST_APPEND || state_q == ST_WCOL) ? acc_row : empty_row),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule

>>> rtl/core/minmax_envelope_history.sv
// Channel   Direction  Handshake              Payload
// items     in         push / full           item_i   (mmeh_pkg::item_t)
// results   out        empty / pop           result_o (mmeh_pkg::result_t)
// config    in         cfg_valid / cfg_ready cfg_index_i, cfg_data_i
//
// Accumulate, reset accumulators, read misses and ignored commands finish at
// dispatch; a read hit then visits ST_RDATA as the history RAM port is registered.
// Append and write column dispatch, then step through the sets, writing one
// history row per active set. Clear band or clear wide sweeps 2**clog2(MAX_COLUMNS)
// rows; clear all and the pass after reset sweep (NUM_BANDS+1)*2**clog2(MAX_COLUMNS)
// rows (1280 at the defaults), and full stays high during the reset pass.
// A column_count write reduces every head pointer bit-serially before the next
// command runs.
// A two-entry command queue and a two-entry result queue decouple both sides.
module minmax_envelope_history #(
  parameter int NUM_BANDS   = 4,
  parameter int NUM_MODES   = 4,
  parameter int MAX_COLUMNS = 256
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  mmeh_pkg::item_t                 item_i,
  output logic                            empty,
  input  logic                            pop,
  output mmeh_pkg::result_t               result_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mmeh_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mmeh_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  logic              front_full;
  logic              init_busy;
  logic              cmd_valid;
  logic              cmd_pop;
  mmeh_pkg::cmd_t    cmd;
  logic              res_push;
  logic              res_full;
  mmeh_pkg::result_t res;

  assign full        = front_full || init_busy;
  assign cfg_ready_o = 1'b1;

  mmeh_front #(
    .NUM_BANDS (NUM_BANDS),
    .NUM_MODES (NUM_MODES)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (push && !full),
    .item_i      (item_i),
    .full_o      (front_full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_pop_i   (cmd_pop)
  );

  mmeh_back #(
    .NUM_BANDS   (NUM_BANDS),
    .NUM_MODES   (NUM_MODES),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (res),
    .init_busy_o (init_busy)
  );

  mmeh_fifo #(
    .WIDTH ($bits(mmeh_pkg::result_t)),
    .DEPTH (2)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop && !empty),
    .data_o  (result_o),
    .empty_o (empty)
  );

`ifndef SYNTH
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !res_full) else $error("result beat pushed into a full queue");
  a_cmd_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop |-> cmd_valid) else $error("command popped from an empty queue");
  a_init_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_busy |-> (full && empty && !cmd_valid))
    else $error("activity during the reset clearing pass");
`endif

endmodule
